### hw/rtl/wfpf_pkg.sv
`default_nettype none
package wfpf_pkg;

    typedef enum logic [1:0] {
        CMD_CLASSIFY = 2'd0,
        CMD_ADD      = 2'd1,
        CMD_DELETE   = 2'd2,
        CMD_NOP      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        RSN_NONE  = 2'd0,
        RSN_DNS   = 2'd1,
        RSN_SPOOF = 2'd2,
        RSN_RULE  = 2'd3
    } reason_t;

    typedef enum logic [2:0] {
        ST_CLASSIFIED = 3'd0,
        ST_ADDED      = 3'd1,
        ST_DUPLICATE  = 3'd2,
        ST_FULL       = 3'd3,
        ST_DELETED    = 3'd4,
        ST_NOT_FOUND  = 3'd5
    } status_t;

    typedef enum logic [0:0] {
        CFG_BLOCK_SPOOFED = 1'b0,
        CFG_BLOCK_DNS     = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        FSM_IDLE    = 2'd0,
        FSM_COMPARE = 2'd1,
        FSM_RESULT  = 2'd2
    } fsm_t;

    localparam logic [31:0] LOOPBACK_ADDR = 32'h7F00_0001;
    localparam logic [15:0] DNS_PORT      = 16'd53;

    typedef struct packed {
        logic [1:0]  command;
        logic        direction;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [7:0]  protocol_number;
        logic [4:0]  field_given_mask;
        logic [15:0] dns_flag_bytes;
        logic [15:0] dns_question_count;
    } req_t;

    typedef struct packed {
        logic        drop;
        logic [1:0]  drop_reason;
        logic [2:0]  command_status;
        logic [4:0]  rule_count;
    } rsp_t;

    // One stored rule in canonical form (unstated fields zero).
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [4:0]  mask;
    } rule_t;

    // Table edit controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic load;    // cell at tail position takes the new rule
        logic shift;   // cells at or above the first equal rule take their neighbor
    } edit_t;

    function automatic rule_t canon(input req_t r);
        rule_t c;
        c.src   = r.field_given_mask[0] ? r.source_address : 32'd0;
        c.dst   = r.field_given_mask[1] ? r.dest_address : 32'd0;
        c.sport = r.field_given_mask[2] ? r.source_port : 16'd0;
        c.dport = r.field_given_mask[3] ? r.destination_port : 16'd0;
        c.proto = r.field_given_mask[4] ? r.protocol_number : 8'd0;
        c.mask  = r.field_given_mask;
        return c;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/wildcard_five_tuple_packet_filter_core.sv
`default_nettype none
// Channel   | Direction | Handshake           | Payload
// in        | input     | in_valid/in_stall   | wfpf_pkg::req_t
// out       | output    | out_valid/out_stall | wfpf_pkg::rsp_t
// cfg       | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
// A request is taken in the idle state and then passes through COMPARE, which registers
// the compare results of every rule cell, and RESULT, which applies the edit and loads
// the output. A new request is taken only once the sequencer is back in the idle state
// and no stalled result still waits.
// Reset clears both rule counts, the control registers and the output valid.
// in_stall is high while a request is in work or a stalled result still waits.
module wildcard_five_tuple_packet_filter_core #(
    parameter int RULES_PER_DIRECTION = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire wfpf_pkg::req_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output wfpf_pkg::rsp_t       out_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic            cfg_index,
    input  wire logic            cfg_data
);
    import wfpf_pkg::*;

    localparam int CW = $clog2(RULES_PER_DIRECTION + 1);
    localparam logic [CW-1:0] FULL = CW'(RULES_PER_DIRECTION);

    fsm_t state_reg, state_next;
    req_t req_reg;
    rsp_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;
    logic [CW-1:0] cnt_reg [2];
    logic [CW-1:0] cnt_next [2];
    logic blk_spoof_reg, blk_dns_reg;
    logic accept;

    edit_t edit_t0, edit_t1;
    logic hit [2];
    logic same [2];

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != FSM_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_spoof_reg <= 1'b0;
            blk_dns_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_idx_t'(cfg_index) == CFG_BLOCK_SPOOFED)
            begin
                blk_spoof_reg <= cfg_data;
            end
            else
            begin
                blk_dns_reg <= cfg_data;
            end
        end
    end

    // Request register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_data;
        end
    end

    // One chain of cells per direction.
    wfpf_table #(.RULES(RULES_PER_DIRECTION)) u_in_tbl (
        .clk(clk), .rst_n(rst_n), .req(req_reg), .edit(edit_t0), .count(cnt_reg[0]),
        .any_hit(hit[0]), .any_same(same[0])
    );
    wfpf_table #(.RULES(RULES_PER_DIRECTION)) u_out_tbl (
        .clk(clk), .rst_n(rst_n), .req(req_reg), .edit(edit_t1), .count(cnt_reg[1]),
        .any_hit(hit[1]), .any_same(same[1])
    );

    // Sequencer and result formation.
    logic dir;
    logic dns_bad, spoof;
    logic [CW-1:0] n;
    logic [CW-1:0] n_new;
    edit_t ed;

    always_comb
    begin
        dir = req_reg.direction;
        n   = cnt_reg[dir];
        n_new = n;
        ed  = '0;
        state_next     = state_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        cnt_next[0]    = cnt_reg[0];
        cnt_next[1]    = cnt_reg[1];
        dns_bad = !dir && blk_dns_reg && req_reg.source_port == DNS_PORT
               && req_reg.dns_flag_bytes[14:11] == 4'd0
               && req_reg.dns_flag_bytes[3:0] == 4'd0
               && req_reg.dns_question_count != 16'd0
               && !req_reg.dns_flag_bytes[10];
        spoof = blk_spoof_reg && (dir ? req_reg.source_address != LOOPBACK_ADDR
                                      : req_reg.source_address == LOOPBACK_ADDR);
        case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = FSM_COMPARE;
                end
            end
            FSM_COMPARE:
            begin
                state_next = FSM_RESULT;
            end
            FSM_RESULT:
            begin
                out_next.drop           = 1'b0;
                out_next.drop_reason    = RSN_NONE;
                out_next.command_status = ST_CLASSIFIED;
                case (cmd_t'(req_reg.command))
                    CMD_CLASSIFY:
                    begin
                        if (dns_bad)
                        begin
                            out_next.drop = 1'b1;
                            out_next.drop_reason = RSN_DNS;
                        end
                        else if (spoof)
                        begin
                            out_next.drop = 1'b1;
                            out_next.drop_reason = RSN_SPOOF;
                        end
                        else if (hit[dir])
                        begin
                            out_next.drop = 1'b1;
                            out_next.drop_reason = RSN_RULE;
                        end
                    end
                    CMD_ADD:
                    begin
                        if (same[dir])
                        begin
                            out_next.command_status = ST_DUPLICATE;
                        end
                        else if (n >= FULL)
                        begin
                            out_next.command_status = ST_FULL;
                        end
                        else
                        begin
                            ed.load = 1'b1;
                            n_new = n + 1'b1;
                            out_next.command_status = ST_ADDED;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (same[dir])
                        begin
                            ed.shift = 1'b1;
                            n_new = n - 1'b1;
                            out_next.command_status = ST_DELETED;
                        end
                        else
                        begin
                            out_next.command_status = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        out_next.command_status = ST_CLASSIFIED;
                    end
                endcase
                cnt_next[dir] = n_new;
                out_next.rule_count = 5'(n_new);
                out_valid_next = 1'b1;
                state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
        edit_t0 = dir ? edit_t'('0) : ed;
        edit_t1 = dir ? ed : edit_t'('0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg[0]    <= cnt_next[0];
            cnt_reg[1]    <= cnt_next[1];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // A result is only loaded when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == FSM_RESULT |-> !(out_valid_reg && out_stall))
        else $error("result overwrites a waiting result");
    // Counts never exceed the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= FULL && cnt_reg[1] <= FULL)
        else $error("rule count out of range");
    // No request is taken while one is in work.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != FSM_IDLE |-> in_stall)
        else $error("request taken while busy");
endmodule
`default_nettype wire

### hw/rtl/wfpf_cell.sv
`default_nettype none
module wfpf_cell (
    input  wire logic             clk,
    input  wire wfpf_pkg::req_t   req,
    input  wire wfpf_pkg::rule_t  new_rule,
    input  wire wfpf_pkg::rule_t  from_next,
    input  wire wfpf_pkg::edit_t  edit,
    input  wire logic             load_here,
    input  wire logic             shift_here,
    output wfpf_pkg::rule_t       rule_out,
    output logic                  hit,
    output logic                  same
);
    import wfpf_pkg::*;

    rule_t rule_reg;
    logic [4:0] m;

    assign rule_out = rule_reg;

    // Packet match: a field counts when both sides state it.
    always_comb
    begin
        m   = rule_reg.mask & req.field_given_mask;
        hit = !(m[0] && rule_reg.src   != req.source_address)
           && !(m[1] && rule_reg.dst   != req.dest_address)
           && !(m[2] && rule_reg.sport != req.source_port)
           && !(m[3] && rule_reg.dport != req.destination_port)
           && !(m[4] && rule_reg.proto != req.protocol_number);
        same = (rule_reg == new_rule);
    end

    // Rule storage: append at the tail or take the neighbor to close a gap.
    always_ff @(posedge clk)
    begin
        if (edit.load && load_here)
        begin
            rule_reg <= new_rule;
        end
        else if (edit.shift && shift_here)
        begin
            rule_reg <= from_next;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/wfpf_table.sv
`default_nettype none
module wfpf_table #(
    parameter int RULES = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire wfpf_pkg::req_t           req,
    input  wire wfpf_pkg::edit_t          edit,
    input  wire logic [$clog2(RULES+1)-1:0] count,
    output logic                          any_hit,
    output logic                          any_same
);
    import wfpf_pkg::*;

    localparam int CW = $clog2(RULES + 1);

    rule_t new_rule;
    rule_t rules [RULES+1];
    logic [RULES-1:0] hit_v;
    logic [RULES-1:0] same_v;
    logic [RULES-1:0] valid_v;
    logic [RULES-1:0] ge_pos;

    assign new_rule = canon(req);
    assign rules[RULES] = '0;

    // Position flags: held entries and entries at or above the first duplicate.
    always_comb
    begin
        for (int i = 0; i < RULES; i++)
        begin
            valid_v[i] = CW'(i) < count;
        end
        ge_pos[0] = same_v[0];
        for (int i = 1; i < RULES; i++)
        begin
            ge_pos[i] = ge_pos[i-1] | same_v[i];
        end
    end

    genvar g;
    generate
        for (g = 0; g < RULES; g++)
        begin : g_cell
            logic h;
            logic s;
            wfpf_cell u_cell (
                .clk        (clk),
                .req        (req),
                .new_rule   (new_rule),
                .from_next  (rules[g+1]),
                .edit       (edit),
                .load_here  (CW'(g) == count),
                .shift_here (ge_pos[g]),
                .rule_out   (rules[g]),
                .hit        (h),
                .same       (s)
            );
            assign hit_v[g]  = h & valid_v[g];
            assign same_v[g] = s & valid_v[g];
        end
    endgenerate

    // Registered summary of the whole chain.
    logic any_hit_reg;
    logic any_same_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_hit_reg  <= 1'b0;
            any_same_reg <= 1'b0;
        end
        else
        begin
            any_hit_reg  <= |hit_v;
            any_same_reg <= |same_v;
        end
    end

    assign any_hit  = any_hit_reg;
    assign any_same = any_same_reg;
endmodule
`default_nettype wire
